/* src/kvf_pkg.sv */
// Shared constants, widths and the saturation helper for the 2D velocity fusion block.
// No dependencies.
`default_nettype none
package kvf_pkg;
	localparam int FRAC    = 24;
	localparam int W       = 32;
	localparam int CFG_W   = 31;
	localparam int OP_W    = W + 1;
	localparam int PROD_W  = 2 * OP_W - FRAC;
	localparam int ACC_W   = PROD_W + 2;
	localparam int DET_W   = 2 * W - FRAC + 1;
	localparam int NUM_W   = OP_W + FRAC;
	localparam int DVD_W   = W + FRAC;
	localparam int CNT_W   = $clog2(DVD_W);
	localparam int ADDR_W  = 4;

	localparam logic [CFG_W-1:0] PROC_NOISE_RST = CFG_W'(1074);
	localparam logic [CFG_W-1:0] MEAS_NOISE_RST = CFG_W'(41943);

	localparam logic [1:0] REG_PROC_X = 2'd0;
	localparam logic [1:0] REG_PROC_Y = 2'd1;
	localparam logic [1:0] REG_MEAS_X = 2'd2;
	localparam logic [1:0] REG_MEAS_Y = 2'd3;

	function automatic logic signed [W-1:0] sat32(input logic signed [ACC_W-1:0] v);
		logic fits;
		fits = (&v[ACC_W-1:W-1]) || !(|v[ACC_W-1:W-1]);
		if (fits)
			return v[W-1:0];
		else if (v[ACC_W-1])
			return {1'b1, {(W-1){1'b0}}};
		else
			return {1'b0, {(W-1){1'b1}}};
	endfunction
endpackage
`default_nettype wire

/* src/kalman_velocity_fusion_2d.sv */
// Top level of the 2D velocity Kalman fusion block: register port, sequencer and
// datapath registers. Depends on kvf_pkg, kvf_mul and kvf_div.
`default_nettype none
// One transaction carries a predicted velocity and an observed velocity (signed
// Q8.24). The block adds the process noise to the stored 2x2 covariance, adds the
// measurement noise, inverts the innovation covariance and returns the fused
// estimate, then updates the covariance (cleared to zero by reset). A zero
// determinant returns the prediction with singular set and keeps the covariance.
// Work runs through one shared 33x33 multiplier (registered, 22 products) and one
// restoring divider (one quotient bit a cycle, four divisions). in_stall is high
// from acceptance until the result is loaded into the output register; a finished
// result waits in the output register while the next transaction may be accepted.
// Noise registers are written over APB at byte addresses 0, 4, 8, 12 (proc x, proc
// y, meas x, meas y); the user must write them only while idle, as the block itself
// does not enforce this.
module kalman_velocity_fusion_2d (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               psel,
	input  wire                               penable,
	input  wire                               pwrite,
	input  wire [kvf_pkg::ADDR_W-1:0]         paddr,
	input  wire [31:0]                        pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready,
	input  wire                               in_valid,
	output logic                              in_stall,
	input  wire signed [31:0]                 pred_vx,
	input  wire signed [31:0]                 pred_vy,
	input  wire signed [31:0]                 obs_vx,
	input  wire signed [31:0]                 obs_vy,
	output logic                              out_valid,
	input  wire                               out_stall,
	output logic signed [31:0]                est_vx,
	output logic signed [31:0]                est_vy,
	output logic                              singular
);
	import kvf_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_PREP = 3'd1;
	localparam logic [2:0] ST_MULA = 3'd2;
	localparam logic [2:0] ST_MULB = 3'd3;
	localparam logic [2:0] ST_DIVS = 3'd4;
	localparam logic [2:0] ST_DIVW = 3'd5;
	localparam logic [2:0] ST_DONE = 3'd6;

	// product program steps
	localparam logic [4:0] J_DET   = 5'd1;
	localparam logic [4:0] J_K     = 5'd2;
	localparam logic [4:0] J_E0    = 5'd10;
	localparam logic [4:0] J_E1    = 5'd12;
	localparam logic [4:0] J_LAST  = 5'd21;

	localparam logic signed [OP_W-1:0] ONE = OP_W'(1) <<< FRAC;

	logic [2:0]              state_q;
	logic [4:0]              j_q;
	logic [1:0]              di_q;
	logic [CFG_W-1:0]        qx_q, qy_q, rx_q, ry_q;
	logic signed [W-1:0]     cov_q [4];
	logic signed [W-1:0]     x0_q, x1_q;
	logic signed [OP_W-1:0]  d0_q, d1_q;
	logic signed [W-1:0]     p00_q, p01_q, p10_q, p11_q, s00_q, s11_q;
	logic signed [DET_W-1:0] det_q;
	logic signed [W-1:0]     inv_q [4];
	logic signed [W-1:0]     k00_q, k01_q, k10_q, k11_q, e0_q, e1_q;
	logic signed [ACC_W-1:0] acc_q;
	logic                    sing_q;

	logic                    wr_en;
	logic signed [W-1:0]     p00_n, p11_n;
	logic signed [OP_W-1:0]  op_a, op_b;
	logic signed [PROD_W-1:0] prod;
	logic signed [ACC_W-1:0] base, sum;
	logic                    sub;
	logic signed [W-1:0]     sum_sat;
	logic                    div_start, div_done;
	logic signed [NUM_W-1:0] div_num;
	logic signed [W-1:0]     div_quo;
	logic                    out_free;

	function automatic logic signed [OP_W-1:0] ext(input logic signed [W-1:0] v);
		return {v[W-1], v};
	endfunction

	// register port
	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_comb begin
		unique case (paddr[3:2])
			REG_PROC_X: prdata = {1'b0, qx_q};
			REG_PROC_Y: prdata = {1'b0, qy_q};
			REG_MEAS_X: prdata = {1'b0, rx_q};
			REG_MEAS_Y: prdata = {1'b0, ry_q};
			default:    prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qx_q <= PROC_NOISE_RST;
			qy_q <= PROC_NOISE_RST;
			rx_q <= MEAS_NOISE_RST;
			ry_q <= MEAS_NOISE_RST;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				REG_PROC_X: qx_q <= pwdata[CFG_W-1:0];
				REG_PROC_Y: qy_q <= pwdata[CFG_W-1:0];
				REG_MEAS_X: rx_q <= pwdata[CFG_W-1:0];
				REG_MEAS_Y: ry_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// P = Phat + Q, S = P + R
	assign p00_n = sat32(ACC_W'(cov_q[0]) + $signed({{(ACC_W-CFG_W){1'b0}}, qx_q}));
	assign p11_n = sat32(ACC_W'(cov_q[3]) + $signed({{(ACC_W-CFG_W){1'b0}}, qy_q}));

	// operand select for the product program
	always_comb begin
		op_a = '0;
		op_b = '0;
		case (j_q)
			5'd0:  begin op_a = ext(s00_q); op_b = ext(s11_q); end
			5'd1:  begin op_a = ext(p01_q); op_b = ext(p10_q); end
			5'd2:  begin op_a = ext(p00_q); op_b = ext(inv_q[0]); end
			5'd3:  begin op_a = ext(p01_q); op_b = ext(inv_q[2]); end
			5'd4:  begin op_a = ext(p00_q); op_b = ext(inv_q[1]); end
			5'd5:  begin op_a = ext(p01_q); op_b = ext(inv_q[3]); end
			5'd6:  begin op_a = ext(p10_q); op_b = ext(inv_q[0]); end
			5'd7:  begin op_a = ext(p11_q); op_b = ext(inv_q[2]); end
			5'd8:  begin op_a = ext(p10_q); op_b = ext(inv_q[1]); end
			5'd9:  begin op_a = ext(p11_q); op_b = ext(inv_q[3]); end
			5'd10: begin op_a = ext(k00_q); op_b = d0_q; end
			5'd11: begin op_a = ext(k01_q); op_b = d1_q; end
			5'd12: begin op_a = ext(k10_q); op_b = d0_q; end
			5'd13: begin op_a = ext(k11_q); op_b = d1_q; end
			5'd14: begin op_a = ONE - ext(k00_q); op_b = ext(p00_q); end
			5'd15: begin op_a = -ext(k01_q);      op_b = ext(p10_q); end
			5'd16: begin op_a = ONE - ext(k00_q); op_b = ext(p01_q); end
			5'd17: begin op_a = -ext(k01_q);      op_b = ext(p11_q); end
			5'd18: begin op_a = -ext(k10_q);      op_b = ext(p00_q); end
			5'd19: begin op_a = ONE - ext(k11_q); op_b = ext(p10_q); end
			5'd20: begin op_a = -ext(k10_q);      op_b = ext(p01_q); end
			5'd21: begin op_a = ONE - ext(k11_q); op_b = ext(p11_q); end
			default: ;
		endcase
	end

	kvf_mul u_mul (
		.clk    (clk),
		.a      (op_a),
		.b      (op_b),
		.prod_q (prod)
	);

	// accumulate: first term of a pair starts from base, second adds (det subtracts)
	assign sub  = (j_q == J_DET);
	always_comb begin
		if (j_q == J_E0)
			base = ACC_W'(x0_q);
		else if (j_q == J_E1)
			base = ACC_W'(x1_q);
		else
			base = '0;
	end
	assign sum     = (j_q[0] ? acc_q : base) + (sub ? -ACC_W'(prod) : ACC_W'(prod));
	assign sum_sat = sat32(sum);

	// numerator: adjugate entry times 2^FRAC
	always_comb begin
		case (di_q)
			2'd0:    div_num = {ext(s11_q), {FRAC{1'b0}}};
			2'd1:    div_num = {-ext(p01_q), {FRAC{1'b0}}};
			2'd2:    div_num = {-ext(p10_q), {FRAC{1'b0}}};
			default: div_num = {ext(s00_q), {FRAC{1'b0}}};
		endcase
	end

	assign div_start = (state_q == ST_DIVS);

	kvf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (det_q),
		.done   (div_done),
		.quo    (div_quo)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign out_free = !out_valid || !out_stall;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			j_q       <= '0;
			di_q      <= '0;
			out_valid <= 1'b0;
			for (int n = 0; n < 4; n++) cov_q[n] <= '0;
		end else begin
			// a result leaving in the cycle a new one is loaded is handled by ST_DONE
			if (out_valid && !out_stall && (state_q != ST_DONE))
				out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid)
						state_q <= ST_PREP;
				end
				ST_PREP: begin
					j_q     <= '0;
					state_q <= ST_MULA;
				end
				ST_MULA: state_q <= ST_MULB;
				ST_MULB: begin
					j_q <= j_q + 1'b1;
					if (j_q == J_DET) begin
						if (sum == '0) begin
							state_q <= ST_DONE;
						end else begin
							di_q    <= '0;
							state_q <= ST_DIVS;
						end
					end else if (j_q == J_LAST) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_MULA;
					end
					case (j_q)
						5'd15: cov_q[0] <= sum_sat;
						5'd17: cov_q[1] <= sum_sat;
						5'd19: cov_q[2] <= sum_sat;
						5'd21: cov_q[3] <= sum_sat;
						default: ;
					endcase
				end
				ST_DIVS: state_q <= ST_DIVW;
				ST_DIVW: begin
					if (div_done) begin
						if (di_q == 2'd3) begin
							j_q     <= J_K;
							state_q <= ST_MULA;
						end else begin
							di_q    <= di_q + 1'b1;
							state_q <= ST_DIVS;
						end
					end
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					x0_q <= pred_vx;
					x1_q <= pred_vy;
					d0_q <= ext(obs_vx) - ext(pred_vx);
					d1_q <= ext(obs_vy) - ext(pred_vy);
				end
			end
			ST_PREP: begin
				p00_q  <= p00_n;
				p01_q  <= cov_q[1];
				p10_q  <= cov_q[2];
				p11_q  <= p11_n;
				s00_q  <= sat32(ACC_W'(p00_n) + $signed({{(ACC_W-CFG_W){1'b0}}, rx_q}));
				s11_q  <= sat32(ACC_W'(p11_n) + $signed({{(ACC_W-CFG_W){1'b0}}, ry_q}));
				sing_q <= 1'b0;
			end
			ST_MULB: begin
				acc_q <= sum;
				case (j_q)
					5'd1: begin
						det_q  <= sum[DET_W-1:0];
						sing_q <= (sum == '0);
					end
					5'd3:  k00_q <= sum_sat;
					5'd5:  k01_q <= sum_sat;
					5'd7:  k10_q <= sum_sat;
					5'd9:  k11_q <= sum_sat;
					5'd11: e0_q  <= sum_sat;
					5'd13: e1_q  <= sum_sat;
					default: ;
				endcase
			end
			ST_DIVW: begin
				if (div_done)
					inv_q[di_q] <= div_quo;
			end
			ST_DONE: begin
				if (out_free) begin
					est_vx   <= sing_q ? x0_q : e0_q;
					est_vy   <= sing_q ? x1_q : e1_q;
					singular <= sing_q;
				end
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

/* src/kvf_mul.sv */
// Shared registered fixed-point multiplier: (a*b) floored by 2^FRAC.
// Depends on kvf_pkg.
`default_nettype none
module kvf_mul (
	input  wire                                    clk,
	input  wire signed [kvf_pkg::OP_W-1:0]         a,
	input  wire signed [kvf_pkg::OP_W-1:0]         b,
	output logic signed [kvf_pkg::PROD_W-1:0]      prod_q
);
	import kvf_pkg::*;

	logic signed [2*OP_W-1:0] full;
	logic signed [2*OP_W-1:0] shifted;

	assign full    = a * b;
	assign shifted = full >>> FRAC;

	always_ff @(posedge clk) begin
		prod_q <= shifted[PROD_W-1:0];
	end
endmodule
`default_nettype wire

/* src/kvf_div.sv */
// Shared radix-2 restoring divider, one quotient bit per cycle, truncating toward
// zero, quotient saturated to 32 bits. Depends on kvf_pkg.
`default_nettype none
module kvf_div (
	input  wire                                   clk,
	input  wire                                   arst_n,
	input  wire                                   start,
	input  wire signed [kvf_pkg::NUM_W-1:0]       num,
	input  wire signed [kvf_pkg::DET_W-1:0]       den,
	output logic                                  done,
	output logic signed [kvf_pkg::W-1:0]          quo
);
	import kvf_pkg::*;

	logic               busy_q;
	logic               done_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               neg_q;
	logic [DET_W-1:0]   den_mag_q;
	logic [DVD_W-1:0]   dvd_q;
	logic [DET_W-1:0]   rem_q;
	logic [NUM_W-1:0]   num_mag;
	logic [DET_W-1:0]   den_mag;
	logic [DET_W:0]     trial;
	logic               ge;
	logic [DET_W:0]     diff;
	logic               big;

	assign num_mag = num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
	assign den_mag = den[DET_W-1] ? DET_W'(-den) : DET_W'(den);
	assign trial   = {rem_q, dvd_q[DVD_W-1]};
	assign ge      = trial >= {1'b0, den_mag_q};
	assign diff    = trial - {1'b0, den_mag_q};

	// magnitude past the signed range
	assign big = neg_q ? ((|dvd_q[DVD_W-1:W]) || (dvd_q[W-1] && (|dvd_q[W-2:0])))
	                   : (|dvd_q[DVD_W-1:W-1]);

	always_comb begin
		if (big)
			quo = neg_q ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
		else
			quo = neg_q ? W'(-dvd_q[W-1:0]) : dvd_q[W-1:0];
	end

	assign done = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DVD_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			neg_q     <= num[NUM_W-1] ^ den[DET_W-1];
			den_mag_q <= den_mag;
			dvd_q     <= num_mag[DVD_W-1:0];
			rem_q     <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[DET_W-1:0] : trial[DET_W-1:0];
			dvd_q <= {dvd_q[DVD_W-2:0], ge};
		end
	end
endmodule
`default_nettype wire

/* tb/kvf_checker.sv */
// Checker for the 2D velocity fusion block: watches both channels and the register
// port, predicts each estimate and compares it. Depends on kvf_pkg.
`default_nettype none
module kvf_checker (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               psel,
	input  wire               penable,
	input  wire               pwrite,
	input  wire               pready,
	input  wire [kvf_pkg::ADDR_W-1:0] paddr,
	input  wire [31:0]        pwdata,
	input  wire               in_valid,
	input  wire               in_stall,
	input  wire signed [31:0] pred_vx,
	input  wire signed [31:0] pred_vy,
	input  wire signed [31:0] obs_vx,
	input  wire signed [31:0] obs_vy,
	input  wire               out_valid,
	input  wire               out_stall,
	input  wire signed [31:0] est_vx,
	input  wire signed [31:0] est_vy,
	input  wire               singular,
	output int                fail_count,
	output int                pending,
	output int                n_singular,
	output int                n_results
);
	import kvf_pkg::*;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic               sing;
	} estimate_t;

	estimate_t          estimate_q[$];
	longint             noise_q[4];
	longint             cov[4];

	function automatic longint clip32(input longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// product shifted down by FRAC, floor rounding (>>> on longint is arithmetic)
	function automatic longint fmul(input longint a, input longint b);
		return (a * b) >>> FRAC;
	endfunction

	function automatic estimate_t fuse(input longint x0, input longint x1,
			input longint y0, input longint y1);
		longint one, p00, p01, p10, p11, s00, s01, s10, s11, det;
		longint i00, i01, i10, i11, k00, k01, k10, k11, d0, d1;
		longint m00, m01, m10, m11;
		estimate_t r;
		one = longint'(1) << FRAC;
		p00 = clip32(cov[0] + noise_q[0]);
		p01 = cov[1];
		p10 = cov[2];
		p11 = clip32(cov[3] + noise_q[1]);
		s00 = clip32(p00 + noise_q[2]);
		s01 = p01;
		s10 = p10;
		s11 = clip32(p11 + noise_q[3]);
		det = fmul(s00, s11) - fmul(s01, s10);
		if (det == 0) begin
			r.vx = x0[31:0];
			r.vy = x1[31:0];
			r.sing = 1'b1;
			return r;
		end
		i00 = clip32((s11 * one) / det);
		i01 = clip32((-s01 * one) / det);
		i10 = clip32((-s10 * one) / det);
		i11 = clip32((s00 * one) / det);
		k00 = clip32(fmul(p00, i00) + fmul(p01, i10));
		k01 = clip32(fmul(p00, i01) + fmul(p01, i11));
		k10 = clip32(fmul(p10, i00) + fmul(p11, i10));
		k11 = clip32(fmul(p10, i01) + fmul(p11, i11));
		d0 = y0 - x0;
		d1 = y1 - x1;
		r.vx = 32'(clip32(x0 + fmul(k00, d0) + fmul(k01, d1)));
		r.vy = 32'(clip32(x1 + fmul(k10, d0) + fmul(k11, d1)));
		r.sing = 1'b0;
		m00 = one - k00;
		m01 = -k01;
		m10 = -k10;
		m11 = one - k11;
		cov[0] = clip32(fmul(m00, p00) + fmul(m01, p10));
		cov[1] = clip32(fmul(m00, p01) + fmul(m01, p11));
		cov[2] = clip32(fmul(m10, p00) + fmul(m11, p10));
		cov[3] = clip32(fmul(m10, p01) + fmul(m11, p11));
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		estimate_t want;
		if (!arst_n) begin
			noise_q[0] = PROC_NOISE_RST;
			noise_q[1] = PROC_NOISE_RST;
			noise_q[2] = MEAS_NOISE_RST;
			noise_q[3] = MEAS_NOISE_RST;
			for (int i = 0; i < 4; i++) cov[i] = 0;
			estimate_q.delete();
			fail_count <= 0;
			pending <= 0;
			n_singular <= 0;
			n_results <= 0;
		end else begin
			if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00)
				noise_q[paddr[3:2]] = longint'(pwdata[30:0]);
			if (in_valid && !in_stall)
				estimate_q.push_back(fuse(pred_vx, pred_vy, obs_vx, obs_vy));
			if (out_valid && !out_stall) begin
				n_results <= n_results + 1;
				if (estimate_q.size() == 0) begin
					if (fail_count < 10)
						$display("unexpected result vx=%h vy=%h sing=%b",
							est_vx, est_vy, singular);
					fail_count <= fail_count + 1;
				end else begin
					want = estimate_q.pop_front();
					if (want.sing) n_singular <= n_singular + 1;
					if (want.vx !== est_vx || want.vy !== est_vy ||
							want.sing !== singular) begin
						if (fail_count < 10)
							$display("mismatch: exp vx=%h vy=%h sing=%b got %h %h %b",
								want.vx, want.vy, want.sing, est_vx, est_vy, singular);
						fail_count <= fail_count + 1;
					end
				end
			end
			pending <= estimate_q.size();
		end
	end
endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Testbench top for the 2D velocity fusion block: clock, reset, register writes,
// stimulus, receiver stalls and verdict. Depends on kvf_pkg and kvf_checker.
`default_nettype none
module tb_top;
	import kvf_pkg::*;

	localparam int N_RANDOM = 1880;
	localparam int WATCHDOG = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [31:0] pred_vx = '0, pred_vy = '0, obs_vx = '0, obs_vy = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [31:0] est_vx, est_vy;
	logic singular;

	int fail_count, pending, n_singular, n_results;
	int idle_cycles = 0;
	bit quiet_mode = 0;      // no random stalls during this stretch
	bit hold_off_req = 0;    // receiver holds off for a long stretch
	bit hold_off_done = 0;

	always #5 clk = ~clk;

	kalman_velocity_fusion_2d u_top (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.in_valid(in_valid), .in_stall(in_stall),
		.pred_vx(pred_vx), .pred_vy(pred_vy), .obs_vx(obs_vx), .obs_vy(obs_vy),
		.out_valid(out_valid), .out_stall(out_stall),
		.est_vx(est_vx), .est_vy(est_vy), .singular(singular)
	);

	kvf_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
		.paddr(paddr), .pwdata(pwdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.pred_vx(pred_vx), .pred_vy(pred_vy), .obs_vx(obs_vx), .obs_vy(obs_vy),
		.out_valid(out_valid), .out_stall(out_stall),
		.est_vx(est_vx), .est_vy(est_vy), .singular(singular),
		.fail_count(fail_count), .pending(pending),
		.n_singular(n_singular), .n_results(n_results)
	);

	// Receiver: random stalls, one long hold-off counted here on request.
	always @(negedge clk) begin
		if (hold_off_req && !hold_off_done) begin
			out_stall <= 1'b1;
			if (idle_cycles >= 0) begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= 1500) begin
					hold_off_done <= 1'b1;
					out_stall <= 1'b0;
				end
			end
		end else
			out_stall <= quiet_mode ? 1'b0 : ($urandom_range(0, 99) < 28);
	end

	// Watchdog: cycles with no transaction on either channel.
	int stuck = 0;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			stuck <= 0;
		else if (arst_n) begin
			stuck <= stuck + 1;
			if (stuck > WATCHDOG) begin
				$display("watchdog expired, %0d results outstanding", pending);
				$display("kalman_velocity_fusion_2d test failed");
				$finish;
			end
		end
	end

	// One APB write; only called while the block is idle.
	task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
		@(negedge clk);
		psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
		paddr <= ADDR_W'({idx, 2'b00}); pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
	endtask

	task automatic set_noise(input logic [31:0] qx, input logic [31:0] qy,
			input logic [31:0] rx, input logic [31:0] ry);
		reg_write(REG_PROC_X, qx);
		reg_write(REG_PROC_Y, qy);
		reg_write(REG_MEAS_X, rx);
		reg_write(REG_MEAS_Y, ry);
	endtask

	// Offer one transaction at the falling edge; hold it until accepted.
	task automatic send_velocity(input logic [31:0] px, input logic [31:0] py,
			input logic [31:0] ox, input logic [31:0] oy, input bit gaps);
		@(negedge clk);
		while (gaps && !quiet_mode && $urandom_range(0, 99) < 28) @(negedge clk);
		in_valid <= 1'b1;
		pred_vx <= px; pred_vy <= py; obs_vx <= ox; obs_vy <= oy;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	// Wait until every expected result has arrived, then for the block to settle.
	task automatic drain();
		while (pending != 0 || out_valid) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	// Mostly modest velocities near each other, sometimes full-range noise.
	function automatic logic [31:0] rand_vel();
		case ($urandom_range(0, 9))
			0: return $urandom();
			1: return {{4{$urandom_range(0, 1) == 1}}, 28'($urandom())};
			default: return 32'($signed(24'($urandom())));
		endcase
	endfunction

	initial begin
		logic [31:0] a, b;
		repeat (12) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Directed: field extremes at reset noise, zero noise forces singular.
		quiet_mode = 1;
		send_velocity(32'h0, 32'h0, 32'h0, 32'h0, 0);
		send_velocity(32'h7fffffff, 32'h80000000, 32'h80000000, 32'h7fffffff, 0);
		send_velocity(32'h01000000, 32'hff000000, 32'h02000000, 32'hfe000000, 0);
		send_velocity(32'hffffffff, 32'h00000001, 32'h55555555, 32'haaaaaaaa, 0);
		drain();
		set_noise(32'h0, 32'h0, 32'h0, 32'h0);
		send_velocity(32'h12345678, 32'h87654321, 32'h0, 32'h7fffffff, 0);
		drain();
		// Top of register range, upper bit of pwdata is dropped.
		set_noise(32'hffffffff, 32'h7fffffff, 32'h7fffffff, 32'hffffffff);
		send_velocity(32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h80000000, 0);
		send_velocity(32'h80000000, 32'h80000000, 32'h7fffffff, 32'h7fffffff, 0);
		drain();
		set_noise(32'd1, 32'd0, 32'd1, 32'd0);
		send_velocity(32'h00100000, 32'hfff00000, 32'h00200000, 32'h0, 0);
		send_velocity(32'h00100000, 32'hfff00000, 32'h00200000, 32'h0, 0);
		drain();
		set_noise(32'h01000000, 32'h00800000, 32'h00400000, 32'h02000000);
		for (int i = 0; i < 8; i++)
			send_velocity(rand_vel(), rand_vel(), rand_vel(), rand_vel(), 0);
		// Sender pauses until every expected result has come.
		drain();

		// Random phases with different noise settings.
		quiet_mode = 0;
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: set_noise(32'd1074, 32'd1074, 32'd41943, 32'd41943);
				1: set_noise($urandom(), $urandom(), $urandom(), $urandom());
				2: set_noise($urandom_range(0, 4), $urandom_range(0, 4),
					$urandom_range(0, 4), $urandom_range(0, 4));
				default: set_noise($urandom_range(0, 32'h02000000),
					$urandom_range(0, 32'h02000000),
					$urandom_range(0, 32'h02000000), $urandom_range(0, 32'h02000000));
			endcase
			if (ph == 3) begin
				quiet_mode = 1;
				hold_off_req = 1;   // receiver backs up while items keep coming
			end
			for (int i = 0; i < N_RANDOM / 6; i++) begin
				a = rand_vel();
				b = rand_vel();
				send_velocity(a, b,
					($urandom_range(0, 3) == 0) ? rand_vel() : a + 32'($signed(20'($urandom()))),
					($urandom_range(0, 3) == 0) ? rand_vel() : b + 32'($signed(20'($urandom()))),
					1);
			end
			quiet_mode = 0;
			drain();
		end

		$display("%0d transactions checked, %0d singular, over several noise settings",
			n_results, n_singular);
		if (fail_count == 0)
			$display("kalman_velocity_fusion_2d test passed");
		else
			$display("kalman_velocity_fusion_2d test failed");
		$finish;
	end
endmodule
`default_nettype wire
